>>> hw/rtl/vdbb_pkg.sv
package vdbb_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int IDX_W        = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int GROUP_SIZE   = 32;
  localparam int NUM_GROUPS   = (MAX_VERTICES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int POS_W        = $clog2(NUM_GROUPS * GROUP_SIZE) + 1;
  localparam int ENTRY_W      = 256;

  localparam logic [31:0] MIN_RESET = 32'h7F7F_FFFF;
  localparam logic [31:0] MAX_RESET = 32'hFF7F_FFFF;

  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [POS_W-1:0]   pos_t;

  typedef struct packed {
    logic hit;
    idx_t idx;
  } match_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } wr_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_GRP,
    S_RED,
    S_UPD
  } state_t;

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:0] > 31'h7F80_0000);
  endfunction

  // IEEE a < b on single bit patterns
  function automatic logic f_less(input logic [31:0] a, input logic [31:0] b);
    logic res;
    res = 1'b0;
    if (is_nan(a) || is_nan(b)) begin
      res = 1'b0;
    end else if ((a[30:0] | b[30:0]) == 31'd0) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = a[31];
    end else if (!a[31]) begin
      res = (a < b);
    end else begin
      res = (a > b);
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/vdbb_if.sv
interface vdbb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] tex_u;
  logic [31:0] tex_v;
  logic [31:0] norm_x;
  logic [31:0] norm_y;
  logic [31:0] norm_z;
  logic        last_in_mesh;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y,
                  norm_z, last_in_mesh, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, norm_x, norm_y,
                norm_z, last_in_mesh, output ready);
endinterface

interface vdbb_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  vertex_index;
  logic        is_new;
  logic        table_full;
  logic [10:0] unique_count;
  logic [31:0] box_min_x;
  logic [31:0] box_min_y;
  logic [31:0] box_min_z;
  logic [31:0] box_max_x;
  logic [31:0] box_max_y;
  logic [31:0] box_max_z;

  modport source (output valid, vertex_index, is_new, table_full, unique_count,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                  input ready);
  modport sink (input valid, vertex_index, is_new, table_full, unique_count,
                box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                output ready);
endinterface

>>> hw/rtl/vdbb_cell.sv
module vdbb_cell (
  input  logic             clk,
  input  vdbb_pkg::entry_t query,
  input  vdbb_pkg::cnt_t   count,
  input  vdbb_pkg::wr_ctl_t wr,
  input  vdbb_pkg::pos_t   my_pos,
  input  vdbb_pkg::match_t acc_in,
  output vdbb_pkg::match_t acc_out
);
  import vdbb_pkg::*;

  entry_t entry;
  logic   hit;
  pos_t   cnt_ext;

  assign cnt_ext = pos_t'(count);

  always_ff @(posedge clk) begin
    if (wr.en && (pos_t'(wr.addr) == my_pos)) begin
      entry <= query;
    end
    hit <= (entry == query) && (my_pos < cnt_ext);
  end

  // entries are unique, so at most one cell hits: OR the index along
  assign acc_out.hit = acc_in.hit | hit;
  assign acc_out.idx = acc_in.idx | (hit ? my_pos[IDX_W-1:0] : '0);
endmodule

>>> hw/rtl/vdbb_group.sv
module vdbb_group (
  input  logic              clk,
  input  vdbb_pkg::entry_t  query,
  input  vdbb_pkg::cnt_t    count,
  input  vdbb_pkg::wr_ctl_t wr,
  input  vdbb_pkg::pos_t    base,
  output vdbb_pkg::match_t  grp_match
);
  import vdbb_pkg::*;

  match_t chain [GROUP_SIZE+1];

  assign chain[0] = '0;

  for (genvar c = 0; c < GROUP_SIZE; c++) begin : g_cell
    vdbb_cell u_cell (
      .clk    (clk),
      .query  (query),
      .count  (count),
      .wr     (wr),
      .my_pos (base + pos_t'(c)),
      .acc_in (chain[c]),
      .acc_out(chain[c+1])
    );
  end

  always_ff @(posedge clk) begin
    grp_match <= chain[GROUP_SIZE];
  end
endmodule

>>> hw/rtl/vertex_dedup_bounding_box_top.sv
// Channel | Dir | Payload
// in_ch   | in  | pos_x..norm_z (8 x 32 bit float patterns), last_in_mesh
// out_ch  | out | vertex_index, is_new, table_full, unique_count, box min/max
//
// Each request goes through accept, parallel compare in every cell, OR of
// the match chain inside each 32-cell group, OR across groups, then update.
// The update cycle waits while a previous result is still held in the output
// register. Reset (rst, synchronous) empties the table and resets the box;
// the cell contents themselves are not cleared.
module vertex_dedup_bounding_box_top (
  input logic       clk,
  input logic       rst,
  vdbb_in_if.sink   in_ch,
  vdbb_out_if.source out_ch
);
  import vdbb_pkg::*;

  state_t      state, state_next;
  entry_t      query;
  logic        last;
  cnt_t        count;
  logic [31:0] box_min [3];
  logic [31:0] box_max [3];
  match_t      grp_match [NUM_GROUPS];
  match_t      red_comb;
  match_t      found;
  wr_ctl_t     wr;
  logic        fire;
  logic        full;
  logic [31:0] new_min [3];
  logic [31:0] new_max [3];
  idx_t        res_idx;
  cnt_t        new_count;
  logic [IDX_W+9:0] idx_ext;
  logic [CNT_W+10:0] cnt_ext;

  assign in_ch.ready = (state == S_IDLE);

  // hold the request for the whole search
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      query <= {in_ch.norm_z, in_ch.norm_y, in_ch.norm_x, in_ch.tex_v,
                in_ch.tex_u, in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
      last  <= in_ch.last_in_mesh;
    end
  end

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    vdbb_group u_group (
      .clk      (clk),
      .query    (query),
      .count    (count),
      .wr       (wr),
      .base     (pos_t'(g * GROUP_SIZE)),
      .grp_match(grp_match[g])
    );
  end

  // combine the group results; at most one group hits
  always_comb begin
    red_comb = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      red_comb = red_comb | grp_match[g];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RED) begin
      found <= red_comb;
    end
  end

  // advance out of the update cycle only when the output slot is free
  assign fire = (state == S_UPD) && (!out_ch.valid || out_ch.ready);
  assign full = !found.hit && (count == cnt_t'(MAX_VERTICES));

  assign wr.en   = fire && !found.hit && !full;
  assign wr.addr = count[IDX_W-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      new_min[k] = box_min[k];
      new_max[k] = box_max[k];
      if (wr.en) begin
        if (!f_less(box_min[k], query[32*k +: 32])) new_min[k] = query[32*k +: 32];
        if (!f_less(query[32*k +: 32], box_max[k])) new_max[k] = query[32*k +: 32];
      end
    end
    new_count = wr.en ? count + cnt_t'(1) : count;
    if (found.hit) begin
      res_idx = found.idx;
    end else if (full) begin
      res_idx = '0;
    end else begin
      res_idx = count[IDX_W-1:0];
    end
    idx_ext = {10'd0, res_idx};
    cnt_ext = {11'd0, new_count};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_ch.valid) state_next = S_CMP;
      S_CMP:   state_next = S_GRP;
      S_GRP:   state_next = S_RED;
      S_RED:   state_next = S_UPD;
      S_UPD:   if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      for (int k = 0; k < 3; k++) begin
        box_min[k] <= MIN_RESET;
        box_max[k] <= MAX_RESET;
      end
    end else begin
      state <= state_next;
      if (fire) begin
        // drop the mesh after its last corner has been reported
        if (last) begin
          count <= '0;
          for (int k = 0; k < 3; k++) begin
            box_min[k] <= MIN_RESET;
            box_max[k] <= MAX_RESET;
          end
        end else begin
          count <= new_count;
          for (int k = 0; k < 3; k++) begin
            box_min[k] <= new_min[k];
            box_max[k] <= new_max[k];
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (fire) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ch.vertex_index <= idx_ext[9:0];
      out_ch.is_new       <= wr.en;
      out_ch.table_full   <= full;
      out_ch.unique_count <= cnt_ext[10:0];
      out_ch.box_min_x    <= new_min[0];
      out_ch.box_min_y    <= new_min[1];
      out_ch.box_min_z    <= new_min[2];
      out_ch.box_max_x    <= new_max[0];
      out_ch.box_max_y    <= new_max[1];
      out_ch.box_max_z    <= new_max[2];
    end
  end
endmodule

>>> verif/vdbb_tb_pkg.sv
`timescale 1ns / 1ps
package vdbb_tb_pkg;

  import vdbb_pkg::*;

  typedef struct {
    logic [31:0] f[8];
    logic        last;
  } corner_t;

  typedef struct {
    logic [9:0]  vertex_index;
    logic        is_new;
    logic        table_full;
    logic [10:0] unique_count;
    logic [31:0] bmin[3];
    logic [31:0] bmax[3];
  } dedup_result_t;

  class dedup_scoreboard;
    logic [255:0]  table_q[$];
    logic [31:0]   run_min[3];
    logic [31:0]   run_max[3];
    dedup_result_t pending_q[$];
    int            errors;

    function new();
      errors = 0;
      clear_mesh();
    endfunction

    function void clear_mesh();
      table_q.delete();
      for (int k = 0; k < 3; k++) begin
        run_min[k] = MIN_RESET;
        run_max[k] = MAX_RESET;
      end
    endfunction

    static function bit fp_nan(logic [31:0] a);
      return a[30:0] > 31'h7F80_0000;
    endfunction

    // IEEE a < b
    static function bit fp_lt(logic [31:0] a, logic [31:0] b);
      if (fp_nan(a) || fp_nan(b)) return 0;
      if ((a[30:0] | b[30:0]) == 0) return 0;
      if (a[31] != b[31]) return a[31];
      return a[31] ? (a > b) : (a < b);
    endfunction

    function void note_corner(corner_t c);
      dedup_result_t r;
      logic [255:0]  key;
      int            hit;
      key = {c.f[7], c.f[6], c.f[5], c.f[4], c.f[3], c.f[2], c.f[1], c.f[0]};
      hit = -1;
      foreach (table_q[j]) if (hit < 0 && table_q[j] === key) hit = j;
      r.is_new = 0;
      r.table_full = 0;
      r.vertex_index = 0;
      if (hit >= 0) begin
        r.vertex_index = 10'(hit);
      end else if (table_q.size() < MAX_VERTICES) begin
        r.vertex_index = 10'(table_q.size());
        table_q.push_back(key);
        r.is_new = 1;
        for (int k = 0; k < 3; k++) begin
          if (!fp_lt(run_min[k], c.f[k])) run_min[k] = c.f[k];
          if (!fp_lt(c.f[k], run_max[k])) run_max[k] = c.f[k];
        end
      end else begin
        r.table_full = 1;
      end
      r.unique_count = 11'(table_q.size());
      r.bmin = run_min;
      r.bmax = run_max;
      pending_q.push_back(r);
      if (c.last) clear_mesh();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] exp);
      $display("mismatch %s: got %h expected %h", what, got, exp);
      errors++;
    endtask

    task check_result(dedup_result_t g);
      dedup_result_t e;
      if (pending_q.size() == 0) begin
        report("unexpected result, index", 32'(g.vertex_index), 32'd0);
        return;
      end
      e = pending_q.pop_front();
      if (g.vertex_index !== e.vertex_index)
        report("vertex_index", 32'(g.vertex_index), 32'(e.vertex_index));
      if (g.is_new !== e.is_new)
        report("is_new", 32'(g.is_new), 32'(e.is_new));
      if (g.table_full !== e.table_full)
        report("table_full", 32'(g.table_full), 32'(e.table_full));
      if (g.unique_count !== e.unique_count)
        report("unique_count", 32'(g.unique_count), 32'(e.unique_count));
      for (int k = 0; k < 3; k++) begin
        if (g.bmin[k] !== e.bmin[k]) report($sformatf("box_min[%0d]", k), g.bmin[k], e.bmin[k]);
        if (g.bmax[k] !== e.bmax[k]) report($sformatf("box_max[%0d]", k), g.bmax[k], e.bmax[k]);
      end
    endtask
  endclass

endpackage

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import vdbb_pkg::*;
  import vdbb_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vdbb_in_if  in_ch ();
  vdbb_out_if out_ch ();

  vertex_dedup_bounding_box_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  dedup_scoreboard mesh_board = new();
  bit              stim_done = 0;
  bit              sink_busy = 1;  // 0 lets the sink run without stalls

  // Pick a gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one request and hold it until accepted; sample acceptance at the
  // rising edge, change inputs only at the falling edge. Valid stays high
  // into the next request when there is no gap.
  task automatic send_corner(corner_t c, bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.pos_x        <= c.f[0];
    in_ch.pos_y        <= c.f[1];
    in_ch.pos_z        <= c.f[2];
    in_ch.tex_u        <= c.f[3];
    in_ch.tex_v        <= c.f[4];
    in_ch.norm_x       <= c.f[5];
    in_ch.norm_y       <= c.f[6];
    in_ch.norm_z       <= c.f[7];
    in_ch.last_in_mesh <= c.last;
    do @(posedge clk); while (!in_ch.ready);
    mesh_board.note_corner(c);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] specials[10] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                  32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
                                  32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001,
                                  32'h8000_0001};
    if ($urandom_range(0, 9) == 0) return specials[$urandom_range(0, 9)];
    return $urandom();
  endfunction

  function automatic corner_t rand_corner();
    corner_t c;
    for (int k = 0; k < 8; k++) c.f[k] = rand_float();
    c.last = 1'b0;
    return c;
  endfunction

  // Output side: stall at random, check every accepted result.
  initial begin
    dedup_result_t g;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_busy && pick_gap() > 0) out_ch.ready <= 1'b0;
      else out_ch.ready <= 1'b1;
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        g.vertex_index = out_ch.vertex_index;
        g.is_new       = out_ch.is_new;
        g.table_full   = out_ch.table_full;
        g.unique_count = out_ch.unique_count;
        g.bmin = '{out_ch.box_min_x, out_ch.box_min_y, out_ch.box_min_z};
        g.bmax = '{out_ch.box_max_x, out_ch.box_max_y, out_ch.box_max_z};
        mesh_board.check_result(g);
      end
    end
  end

  initial begin
    corner_t c, pool[$];
    int      n;
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.tex_u = '0; in_ch.tex_v = '0;
    in_ch.norm_x = '0; in_ch.norm_y = '0; in_ch.norm_z = '0;
    in_ch.last_in_mesh = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty mesh box, signed zeros, NaN, infinities.
    c.last = 1'b1;
    for (int k = 0; k < 8; k++) c.f[k] = 32'h0000_0000;
    send_corner(c, 0);                        // one-corner mesh
    c.last = 1'b0;
    send_corner(c, 0);
    send_corner(c, 0);                        // hit on entry 0
    for (int k = 0; k < 8; k++) c.f[k] = 32'h8000_0000;
    send_corner(c, 0);                        // -0 replaces +0 in box
    for (int k = 0; k < 8; k++) c.f[k] = 32'hFFFF_FFFF;
    send_corner(c, 0);                        // NaN taken into box
    for (int k = 0; k < 8; k++) c.f[k] = 32'h7F80_0000;
    send_corner(c, 0);
    for (int k = 0; k < 8; k++) c.f[k] = 32'hFF80_0000;
    send_corner(c, 0);
    for (int k = 0; k < 8; k++) c.f[k] = 32'h3F80_0000;
    c.f[7] = 32'h3F80_0001;                   // differs only in last word
    send_corner(c, 0);
    c.f[7] = 32'h3F80_0000;
    send_corner(c, 0);
    c.last = 1'b1;
    send_corner(c, 0);                        // hit as last corner

    // Fill the table to the brim, then overflow it; each miss beyond
    // capacity reports table full. Sink runs without stalls to keep it quick.
    sink_busy = 0;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      c = rand_corner();
      c.f[7] = j;
      c.f[6] = 32'h5A5A_0000;
      send_corner(c, 0);
    end
    c = rand_corner();
    c.f[6] = 32'h1234_5678;
    send_corner(c, 0);                        // miss on a full table
    c.f[7] = 5; c.f[6] = 32'h1234_5678;
    send_corner(c, 0);
    c.last = 1'b1;
    send_corner(c, 0);
    sink_busy = 1;

    // Random meshes: mostly re-used corners from a small pool, some fresh.
    n = 0;
    while (n < 450) begin
      int len;
      len = $urandom_range(1, 40);
      pool.delete();
      for (int j = 0; j < len && n < 450; j++, n++) begin
        if (pool.size() > 0 && $urandom_range(0, 99) < 55)
          c = pool[$urandom_range(0, pool.size() - 1)];
        else begin
          c = rand_corner();
          pool.push_back(c);
        end
        c.last = (j == len - 1) || ($urandom_range(0, 199) == 0);
        send_corner(c, 1);
      end
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (mesh_board.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mesh_board.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
